// ===== sv/ptpng_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptpng_pkg
// Shared constants and types of the drum pad trigger: per-key state row,
// trigger settings and the note event passed to the output stage.
// ----------------------------------------------------------------------------
package ptpng_pkg;

  localparam int NUM_KEYS      = 64;
  localparam int SAMPLE_BITS   = 12;
  localparam int KEY_BITS      = 6;
  localparam int WAIT_BITS     = 8;
  localparam int CNT_BITS      = 16;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 16;

  localparam logic [SAMPLE_BITS-1:0] THRESHOLD_RST = 12'h240;
  localparam logic [WAIT_BITS-1:0]   WAIT_RST      = 8'd1;
  localparam logic [CNT_BITS-1:0]    LOCKOUT_RST   = 16'd15;
  localparam logic [CNT_BITS-1:0]    NOTE_LEN_RST  = 16'd90;
  localparam logic [CNT_BITS-1:0]    NOTE_LEN_MIN  = 16'd2;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_THRESHOLD = 3'd0,
    CFG_WAIT      = 3'd1,
    CFG_LOCKOUT   = 3'd2,
    CFG_NOTE_LEN  = 3'd3,
    CFG_SUSTAIN   = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] peak;
    logic [WAIT_BITS-1:0]   wait_cnt;
    logic [CNT_BITS-1:0]    lock_cnt;
    logic [CNT_BITS-1:0]    len_cnt;
  } key_state_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] thr;
    logic [WAIT_BITS-1:0]   wait_ticks;
    logic [CNT_BITS-1:0]    lock_ticks;
    logic [CNT_BITS-1:0]    eff_len;
    logic                   sustain;
  } key_cfg_t;

  typedef struct packed {
    logic                   valid;
    logic                   on;
    logic [SAMPLE_BITS-1:0] peak;
  } note_evt_t;

endpackage

// ===== sv/ptpng_key_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptpng_key_store
// Per-key state memory, one row per key, registered read. A row never
// written since reset reads as all zero through its valid bit.
// ----------------------------------------------------------------------------
module ptpng_key_store (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          rd_en_i,
  input  logic [ptpng_pkg::KEY_BITS-1:0] rd_addr_i,
  input  logic                          wr_en_i,
  input  logic [ptpng_pkg::KEY_BITS-1:0] wr_addr_i,
  input  ptpng_pkg::key_state_t         wr_data_i,
  output ptpng_pkg::key_state_t         rd_data_o
);
  import ptpng_pkg::*;

  key_state_t           mem [NUM_KEYS];
  logic [NUM_KEYS-1:0]  row_valid_q;
  key_state_t           rdata_q;
  logic                 rvalid_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rdata_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
      rvalid_q    <= 1'b0;
    end else begin
      if (wr_en_i) begin
        row_valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rvalid_q <= row_valid_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rvalid_q ? rdata_q : '0;

endmodule

// ===== sv/ptpng_key_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptpng_key_unit
// Tick update of one key: arm, note-on, note-off and countdowns. Shared by
// all keys as the tick walk steps through the store.
// ----------------------------------------------------------------------------
module ptpng_key_unit (
  input  ptpng_pkg::key_state_t cur_i,
  input  ptpng_pkg::key_cfg_t   cfg_i,
  output ptpng_pkg::key_state_t nxt_o,
  output ptpng_pkg::note_evt_t  evt_o
);
  import ptpng_pkg::*;

  logic                 arm;
  logic                 on;
  logic                 off;
  logic [WAIT_BITS-1:0] wait1;
  logic [CNT_BITS-1:0]  lock1;
  logic [CNT_BITS-1:0]  len1;

  always_comb begin
    arm   = (cur_i.peak >= cfg_i.thr) && (cur_i.lock_cnt == '0) && (cur_i.wait_cnt == '0);
    wait1 = arm ? cfg_i.wait_ticks : cur_i.wait_cnt;
    on    = (wait1 == WAIT_BITS'(1));
    lock1 = on ? cfg_i.lock_ticks : cur_i.lock_cnt;
    len1  = on ? cfg_i.eff_len : cur_i.len_cnt;
    off   = (len1 == CNT_BITS'(1));

    // Count wait down while gathering, otherwise drop the peak
    nxt_o.wait_cnt = (wait1 != '0) ? wait1 - WAIT_BITS'(1) : wait1;
    nxt_o.peak     = (wait1 != '0) ? cur_i.peak : '0;
    nxt_o.lock_cnt = (lock1 != '0) ? lock1 - CNT_BITS'(1) : lock1;
    nxt_o.len_cnt  = ((len1 != '0) && !cfg_i.sustain) ? len1 - CNT_BITS'(1) : len1;

    // Note length is at least two, so on and off never meet in one tick
    evt_o.valid = on | off;
    evt_o.on    = on;
    evt_o.peak  = on ? cur_i.peak : '0;
  end

endmodule

// ===== sv/pad_trigger_peak_note_gen.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pad_trigger_peak_note_gen
// Drum pad trigger: per-key peak hold, hit arming, retrigger lockout and
// automatic note-off, driven by sensor samples and millisecond ticks.
// ----------------------------------------------------------------------------
// A sample for a key in range steps through accept, row read and write back
// before the next item is accepted. A tick walks all NUM_KEYS keys through
// one shared key update unit, each key read from the key store and then
// updated and written back, followed by a closing step; the walk holds when
// the result side stalls. Each tick gives one result per key event in key
// order, the final one flagged by last_event_o; a tick without events gives
// none. Configuration is written without wait (cfg_ready_o is always high)
// and must only be written while the block is idle.
// ----------------------------------------------------------------------------
module pad_trigger_peak_note_gen (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,

  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [ptpng_pkg::CFG_IDX_BITS-1:0]   cfg_index_i,
  input  logic [ptpng_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,

  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 func_i,
  input  logic [ptpng_pkg::KEY_BITS-1:0]       key_index_i,
  input  logic [ptpng_pkg::SAMPLE_BITS-1:0]    sample_value_i,

  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [ptpng_pkg::KEY_BITS-1:0]       event_key_o,
  output logic                                 note_on_o,
  output logic [ptpng_pkg::SAMPLE_BITS-1:0]    hit_peak_o,
  output logic                                 last_event_o
);
  import ptpng_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_RD    = 4'b0010,
    S_UPD   = 4'b0100,
    S_FLUSH = 4'b1000
  } state_e;

  localparam logic [KEY_BITS-1:0] KEY_LAST = KEY_BITS'(NUM_KEYS - 1);

  state_e state_q, state_d;

  logic [SAMPLE_BITS-1:0] thr_q;
  logic [WAIT_BITS-1:0]   wait_ticks_q;
  logic [CNT_BITS-1:0]    lock_ticks_q;
  logic [CNT_BITS-1:0]    note_len_q;
  logic                   sustain_q;
  key_cfg_t               key_cfg;

  logic                   tick_q;
  logic [KEY_BITS-1:0]    key_q, key_d;
  logic [SAMPLE_BITS-1:0] sample_q;

  logic                   pend_valid_q, pend_valid_d;
  logic                   pend_on_q, pend_on_d;
  logic [KEY_BITS-1:0]    pend_key_q, pend_key_d;
  logic [SAMPLE_BITS-1:0] pend_peak_q, pend_peak_d;

  logic                   out_valid_q, out_valid_d;
  logic                   out_on_q, out_on_d;
  logic [KEY_BITS-1:0]    out_key_q, out_key_d;
  logic [SAMPLE_BITS-1:0] out_peak_q, out_peak_d;
  logic                   out_last_q, out_last_d;

  logic                   in_fire;
  logic                   in_range;
  logic                   out_free;
  logic                   rd_en;
  logic                   wr_en;
  key_state_t             row;
  key_state_t             row_tick;
  key_state_t             wr_row;
  note_evt_t              evt;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q        <= THRESHOLD_RST;
      wait_ticks_q <= WAIT_RST;
      lock_ticks_q <= LOCKOUT_RST;
      note_len_q   <= NOTE_LEN_RST;
      sustain_q    <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_THRESHOLD: thr_q        <= cfg_data_i[SAMPLE_BITS-1:0];
        CFG_WAIT:      wait_ticks_q <= cfg_data_i[WAIT_BITS-1:0];
        CFG_LOCKOUT:   lock_ticks_q <= cfg_data_i[CNT_BITS-1:0];
        CFG_NOTE_LEN:  note_len_q   <= cfg_data_i[CNT_BITS-1:0];
        CFG_SUSTAIN:   sustain_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    key_cfg.thr        = thr_q;
    key_cfg.wait_ticks = wait_ticks_q;
    key_cfg.lock_ticks = lock_ticks_q;
    key_cfg.eff_len    = (note_len_q < NOTE_LEN_MIN) ? NOTE_LEN_MIN : note_len_q;
    key_cfg.sustain    = sustain_q;
  end

  ptpng_key_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (key_q),
    .wr_en_i   (wr_en),
    .wr_addr_i (key_q),
    .wr_data_i (wr_row),
    .rd_data_o (row)
  );

  ptpng_key_unit u_unit (
    .cur_i (row),
    .cfg_i (key_cfg),
    .nxt_o (row_tick),
    .evt_o (evt)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign in_range   = ({1'b0, key_index_i} < (KEY_BITS + 1)'(NUM_KEYS));
  assign out_free   = !out_valid_q || out_ready_i;
  assign rd_en      = (state_q == S_RD);

  always_comb begin
    wr_row = row;
    if (tick_q) begin
      wr_row = row_tick;
    end else if (row.peak < sample_q) begin
      wr_row.peak = sample_q;
    end
  end

  always_comb begin
    state_d      = state_q;
    key_d        = key_q;
    wr_en        = 1'b0;
    pend_valid_d = pend_valid_q;
    pend_on_d    = pend_on_q;
    pend_key_d   = pend_key_q;
    pend_peak_d  = pend_peak_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_on_d     = out_on_q;
    out_key_d    = out_key_q;
    out_peak_d   = out_peak_q;
    out_last_d   = out_last_q;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          key_d = func_i ? '0 : key_index_i;
          if (func_i || in_range) begin
            state_d = S_RD;
          end
        end
      end
      S_RD: begin
        state_d = S_UPD;
      end
      S_UPD: begin
        if (!tick_q) begin
          wr_en   = 1'b1;
          state_d = S_IDLE;
        end else if (!(evt.valid && pend_valid_q && !out_free)) begin
          wr_en = 1'b1;
          if (evt.valid) begin
            // Move the held event out; it is not the last one of this tick
            if (pend_valid_q) begin
              out_valid_d = 1'b1;
              out_on_d    = pend_on_q;
              out_key_d   = pend_key_q;
              out_peak_d  = pend_peak_q;
              out_last_d  = 1'b0;
            end
            pend_valid_d = 1'b1;
            pend_on_d    = evt.on;
            pend_key_d   = key_q;
            pend_peak_d  = evt.peak;
          end
          if (key_q == KEY_LAST) begin
            state_d = S_FLUSH;
          end else begin
            key_d   = key_q + KEY_BITS'(1);
            state_d = S_RD;
          end
        end
      end
      S_FLUSH: begin
        if (!pend_valid_q) begin
          state_d = S_IDLE;
        end else if (out_free) begin
          out_valid_d  = 1'b1;
          out_on_d     = pend_on_q;
          out_key_d    = pend_key_q;
          out_peak_d   = pend_peak_q;
          out_last_d   = 1'b1;
          pend_valid_d = 1'b0;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      key_q        <= '0;
    end else begin
      state_q      <= state_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
      key_q        <= key_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      tick_q   <= func_i;
      sample_q <= sample_value_i;
    end
    pend_on_q   <= pend_on_d;
    pend_key_q  <= pend_key_d;
    pend_peak_q <= pend_peak_d;
    out_on_q    <= out_on_d;
    out_key_q   <= out_key_d;
    out_peak_q  <= out_peak_d;
    out_last_q  <= out_last_d;
  end

  assign out_valid_o  = out_valid_q;
  assign event_key_o  = out_key_q;
  assign note_on_o    = out_on_q;
  assign hit_peak_o   = out_peak_q;
  assign last_event_o = out_last_q;

  a_idle_no_pending : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !pend_valid_q
  ) else $error("held event left over after tick walk");

  a_sample_one_update : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPD && !tick_q) |=> (state_q == S_IDLE)
  ) else $error("sample update did not return to idle");

  a_flush_after_last_key : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FLUSH) |-> (key_q == KEY_LAST)
  ) else $error("tick walk closed before the last key");

  a_last_only_from_flush : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_q && out_valid_d && out_last_d) |-> (state_q == S_FLUSH)
  ) else $error("final event flag raised outside the closing step");

endmodule
